/* rtl/bfd_pkg.sv */
// Shared constants and types of the box filter downscaler.
package bfd_pkg;

    localparam int unsigned MAX_WIDTH = 4096;
    localparam int unsigned CFG_W     = 13;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned POS_W     = 12;
    localparam int unsigned ADDR_W    = $clog2(MAX_WIDTH);
    localparam int unsigned SUM_W     = 2 * CFG_W + PIX_W;
    localparam int unsigned AREA_W    = 2 * CFG_W;
    localparam int unsigned CNT_W     = $clog2(SUM_W + 1);
    localparam int unsigned SCNT_W    = $clog2(CFG_W + 1);
    localparam int unsigned IDX_W     = 2;

    localparam logic [IDX_W-1:0] REG_IN_WIDTH   = 2'd0;
    localparam logic [IDX_W-1:0] REG_IN_HEIGHT  = 2'd1;
    localparam logic [IDX_W-1:0] REG_OUT_WIDTH  = 2'd2;
    localparam logic [IDX_W-1:0] REG_OUT_HEIGHT = 2'd3;

    typedef struct packed {
        logic              rd_en;
        logic              acc;
        logic              first;
        logic              div_step;
        logic [ADDR_W-1:0] addr;
    } t_lane_ctl;

endpackage

/* rtl/bfd_ram.sv */
// Generic single-clock RAM with one write port and a registered read port.
module bfd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/bfd_scale.sv */
// Scale factor dividers and box area product for the downscaler.
module bfd_scale (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [bfd_pkg::CFG_W-1:0]   i_in_width,
    input  logic [bfd_pkg::CFG_W-1:0]   i_in_height,
    input  logic [bfd_pkg::CFG_W-1:0]   i_out_width,
    input  logic [bfd_pkg::CFG_W-1:0]   i_out_height,
    output logic                        o_busy,
    output logic [bfd_pkg::CFG_W-1:0]   o_rows_per_box,
    output logic [bfd_pkg::CFG_W-1:0]   o_cols_per_box,
    output logic [bfd_pkg::AREA_W-1:0]  o_area
);

    localparam int unsigned W = bfd_pkg::CFG_W;

    logic [bfd_pkg::SCNT_W-1:0] r_cnt, n_cnt;
    logic                       r_busy, n_busy;
    logic                       r_area_pend, n_area_pend;
    logic [W-1:0]               r_rq, n_rq, r_cq, n_cq;
    logic [W-1:0]               r_rrem, n_rrem, r_crem, n_crem;
    logic [bfd_pkg::AREA_W-1:0] r_area, n_area;
    logic [W:0]                 rsh, csh, rdif, cdif;

    always_comb begin
        n_cnt       = r_cnt;
        n_busy      = r_busy;
        n_area_pend = 1'b0;
        n_rq        = r_rq;
        n_cq        = r_cq;
        n_rrem      = r_rrem;
        n_crem      = r_crem;
        n_area      = r_area;
        rsh  = {r_rrem, r_rq[W-1]};
        csh  = {r_crem, r_cq[W-1]};
        rdif = rsh - {1'b0, i_out_height};
        cdif = csh - {1'b0, i_out_width};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rq   = i_in_height;
            n_cq   = i_in_width;
            n_rrem = '0;
            n_crem = '0;
        end else if (r_busy && !r_area_pend) begin
            if (rdif[W]) begin
                n_rrem = rsh[W-1:0];
                n_rq   = {r_rq[W-2:0], 1'b0};
            end else begin
                n_rrem = rdif[W-1:0];
                n_rq   = {r_rq[W-2:0], 1'b1};
            end
            if (cdif[W]) begin
                n_crem = csh[W-1:0];
                n_cq   = {r_cq[W-2:0], 1'b0};
            end else begin
                n_crem = cdif[W-1:0];
                n_cq   = {r_cq[W-2:0], 1'b1};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == bfd_pkg::SCNT_W'(W - 1)) begin
                n_area_pend = 1'b1;
            end
        end else if (r_busy) begin
            if (i_out_height == '0) begin
                n_rq = '0;
            end
            if (i_out_width == '0) begin
                n_cq = '0;
            end
            n_area = (i_out_height == '0 || i_out_width == '0) ? '0 :
                     bfd_pkg::AREA_W'(r_rq) * bfd_pkg::AREA_W'(r_cq);
            n_busy = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_area_pend <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_busy      <= n_busy;
            r_area_pend <= n_area_pend;
            r_cnt       <= n_cnt;
        end
        r_rq   <= n_rq;
        r_cq   <= n_cq;
        r_rrem <= n_rrem;
        r_crem <= n_crem;
        r_area <= n_area;
    end

    assign o_busy         = r_busy;
    assign o_rows_per_box = r_rq;
    assign o_cols_per_box = r_cq;
    assign o_area         = r_area;

endmodule

/* rtl/bfd_lane.sv */
// One colour channel lane: column sum store, accumulator and mean divider.
module bfd_lane (
    input  logic                        i_clk,
    input  bfd_pkg::t_lane_ctl          i_ctl,
    input  logic [bfd_pkg::PIX_W-1:0]   i_pix,
    input  logic [bfd_pkg::AREA_W-1:0]  i_area,
    output logic [bfd_pkg::PIX_W-1:0]   o_mean
);

    localparam int unsigned SW = bfd_pkg::SUM_W;
    localparam int unsigned AW = bfd_pkg::AREA_W;

    logic [SW-1:0] rd_sum, new_sum;
    logic [SW-1:0] r_dvd, n_dvd;
    logic [AW-1:0] r_rem, n_rem;
    logic [AW:0]   sh, dif;

    bfd_ram #(
        .WIDTH (SW),
        .DEPTH (bfd_pkg::MAX_WIDTH)
    ) u_sums (
        .i_clk   (i_clk),
        .i_we    (i_ctl.acc),
        .i_waddr (i_ctl.addr),
        .i_wdata (new_sum),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_ctl.addr),
        .o_rdata (rd_sum)
    );

    assign new_sum = i_ctl.first ? SW'(i_pix) : rd_sum + SW'(i_pix);

    always_comb begin
        n_dvd = r_dvd;
        n_rem = r_rem;
        sh    = {r_rem, r_dvd[SW-1]};
        dif   = sh - {1'b0, i_area};
        if (i_ctl.acc) begin
            n_dvd = new_sum;
            n_rem = '0;
        end else if (i_ctl.div_step) begin
            if (dif[AW]) begin
                n_rem = sh[AW-1:0];
                n_dvd = {r_dvd[SW-2:0], 1'b0};
            end else begin
                n_rem = dif[AW-1:0];
                n_dvd = {r_dvd[SW-2:0], 1'b1};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_rem <= n_rem;
    end

    assign o_mean = r_dvd[bfd_pkg::PIX_W-1:0];

endmodule

/* rtl/box_filter_downscaler.sv */
// Top level of the box filter downscaler: raster control, lanes and result register.
//
// Channel  Direction  Handshake                 Payload
// in       into       i_in_valid / o_in_stall   i_in_red, i_in_green, i_in_blue, i_start_of_frame
// out      out of     o_out_valid / i_out_stall o_out_red .. o_frame_done
// cfg      into       i_cfg_we                  i_cfg_idx, i_cfg_data
//
// A pixel outside any box only moves the raster position; a pixel inside a box passes the read and
// accumulate states, and one that completes a box also runs the bit-serial mean divider.
// After reset and after every configuration write the scale dividers run, and the
// input is stalled while they do.
// A finished result waits in the output register while the next pixel is worked on.
module box_filter_downscaler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bfd_pkg::IDX_W-1:0]     i_cfg_idx,
    input  logic [bfd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bfd_pkg::PIX_W-1:0]     i_in_red,
    input  logic [bfd_pkg::PIX_W-1:0]     i_in_green,
    input  logic [bfd_pkg::PIX_W-1:0]     i_in_blue,
    input  logic                          i_start_of_frame,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bfd_pkg::PIX_W-1:0]     o_out_red,
    output logic [bfd_pkg::PIX_W-1:0]     o_out_green,
    output logic [bfd_pkg::PIX_W-1:0]     o_out_blue,
    output logic [bfd_pkg::POS_W-1:0]     o_result_column,
    output logic [bfd_pkg::POS_W-1:0]     o_result_row,
    output logic                          o_frame_done
);

    localparam int unsigned W  = bfd_pkg::CFG_W;
    localparam int unsigned PW = bfd_pkg::PIX_W;

    typedef enum logic [2:0] {S_IDLE, S_RD, S_ACC, S_DIV, S_OUT} t_state;

    t_state r_state, n_state;

    logic [W-1:0] r_in_width, r_in_height, r_out_width, r_out_height;
    logic         r_cfg_start;
    logic         scale_busy;
    logic [W-1:0] rows_per_box, cols_per_box;
    logic [bfd_pkg::AREA_W-1:0] area;

    logic [W-1:0] r_ic, r_ir, r_cwb, r_rwb, r_bc, r_br;
    logic [W-1:0] n_ic, n_ir, n_cwb, n_rwb, n_bc, n_br;
    logic [W-1:0] e_ic, e_ir, e_cwb, e_rwb, e_bc, e_br;
    logic [W:0]   c1, r1, ic1, ir1, bc1, br1;

    logic sizes_ok, in_box, emit, first, fdone, accept;

    logic [PW-1:0]                r_red, r_green, r_blue;
    logic                         r_first, r_emit, r_fd;
    logic [bfd_pkg::ADDR_W-1:0]   r_addr;
    logic [bfd_pkg::POS_W-1:0]    r_col, r_row;
    logic [bfd_pkg::CNT_W-1:0]    r_cnt, n_cnt;

    logic                         r_ov;
    logic [PW-1:0]                r_or, r_og, r_ob;
    logic [bfd_pkg::POS_W-1:0]    r_ocol, r_orow;
    logic                         r_ofd;
    logic                         load_out;

    bfd_pkg::t_lane_ctl lane_ctl;
    logic [PW-1:0]      mean_r, mean_g, mean_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= W'(640);
            r_in_height  <= W'(480);
            r_out_width  <= W'(640);
            r_out_height <= W'(480);
            r_cfg_start  <= 1'b1;
        end else begin
            r_cfg_start <= i_cfg_we;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    bfd_pkg::REG_IN_WIDTH:   r_in_width   <= i_cfg_data;
                    bfd_pkg::REG_IN_HEIGHT:  r_in_height  <= i_cfg_data;
                    bfd_pkg::REG_OUT_WIDTH:  r_out_width  <= i_cfg_data;
                    bfd_pkg::REG_OUT_HEIGHT: r_out_height <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    bfd_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (r_cfg_start),
        .i_in_width     (r_in_width),
        .i_in_height    (r_in_height),
        .i_out_width    (r_out_width),
        .i_out_height   (r_out_height),
        .o_busy         (scale_busy),
        .o_rows_per_box (rows_per_box),
        .o_cols_per_box (cols_per_box),
        .o_area         (area)
    );

    assign o_in_stall = (r_state != S_IDLE) || scale_busy || r_cfg_start;
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        e_ic  = i_start_of_frame ? '0 : r_ic;
        e_ir  = i_start_of_frame ? '0 : r_ir;
        e_cwb = i_start_of_frame ? '0 : r_cwb;
        e_rwb = i_start_of_frame ? '0 : r_rwb;
        e_bc  = i_start_of_frame ? '0 : r_bc;
        e_br  = i_start_of_frame ? '0 : r_br;

        sizes_ok = (r_out_width != '0) && (r_out_height != '0) &&
                   (r_out_width <= r_in_width) && (r_out_height <= r_in_height) &&
                   ({1'b0, r_out_width} <= (W + 1)'(bfd_pkg::MAX_WIDTH));
        in_box = sizes_ok && (e_bc < r_out_width) && (e_br < r_out_height);
        c1  = {1'b0, e_cwb} + 1'b1;
        r1  = {1'b0, e_rwb} + 1'b1;
        bc1 = {1'b0, e_bc} + 1'b1;
        br1 = {1'b0, e_br} + 1'b1;
        ic1 = {1'b0, e_ic} + 1'b1;
        ir1 = {1'b0, e_ir} + 1'b1;
        emit  = in_box && (r1 >= {1'b0, rows_per_box}) && (c1 >= {1'b0, cols_per_box});
        first = (e_rwb == '0) && (e_cwb == '0);
        fdone = (bc1 == {1'b0, r_out_width}) && (br1 == {1'b0, r_out_height});

        n_cwb = e_cwb;
        n_bc  = e_bc;
        n_rwb = e_rwb;
        n_br  = e_br;
        n_ir  = e_ir;
        n_ic  = ic1[W-1:0];
        if (sizes_ok) begin
            if (c1 >= {1'b0, cols_per_box}) begin
                n_cwb = '0;
                if (e_bc < r_out_width) begin
                    n_bc = bc1[W-1:0];
                end
            end else begin
                n_cwb = c1[W-1:0];
            end
            if (n_bc > r_out_width) begin
                n_bc = r_out_width;
            end
        end
        if (ic1 >= {1'b0, r_in_width}) begin
            n_ic  = '0;
            n_cwb = '0;
            n_bc  = '0;
            if (r1 >= {1'b0, rows_per_box}) begin
                n_rwb = '0;
                if (e_br < r_out_height) begin
                    n_br = br1[W-1:0];
                end
            end else begin
                n_rwb = r1[W-1:0];
            end
            if (n_br > r_out_height) begin
                n_br = r_out_height;
            end
            if (ir1 >= {1'b0, r_in_height}) begin
                n_ir  = '0;
                n_rwb = '0;
                n_br  = '0;
            end else begin
                n_ir = ir1[W-1:0];
            end
        end
    end

    assign load_out = (r_state == S_OUT) && (!r_ov || !i_out_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (accept && in_box) begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                n_cnt   = '0;
                n_state = r_emit ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == bfd_pkg::CNT_W'(bfd_pkg::SUM_W - 1)) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_ic    <= '0;
            r_ir    <= '0;
            r_cwb   <= '0;
            r_rwb   <= '0;
            r_bc    <= '0;
            r_br    <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (accept) begin
                r_ic  <= n_ic;
                r_ir  <= n_ir;
                r_cwb <= n_cwb;
                r_rwb <= n_rwb;
                r_bc  <= n_bc;
                r_br  <= n_br;
            end
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_red   <= i_in_red;
            r_green <= i_in_green;
            r_blue  <= i_in_blue;
            r_first <= first;
            r_emit  <= emit;
            r_fd    <= fdone;
            r_addr  <= e_bc[bfd_pkg::ADDR_W-1:0];
            r_col   <= e_bc[bfd_pkg::POS_W-1:0];
            r_row   <= e_br[bfd_pkg::POS_W-1:0];
        end
        if (load_out) begin
            r_or   <= mean_r;
            r_og   <= mean_g;
            r_ob   <= mean_b;
            r_ocol <= r_col;
            r_orow <= r_row;
            r_ofd  <= r_fd;
        end
    end

    always_comb begin
        lane_ctl.rd_en    = (r_state == S_RD);
        lane_ctl.acc      = (r_state == S_ACC);
        lane_ctl.first    = r_first;
        lane_ctl.div_step = (r_state == S_DIV);
        lane_ctl.addr     = r_addr;
    end

    bfd_lane u_lane_r (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_pix  (r_red),
        .i_area (area),
        .o_mean (mean_r)
    );

    bfd_lane u_lane_g (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_pix  (r_green),
        .i_area (area),
        .o_mean (mean_g)
    );

    bfd_lane u_lane_b (
        .i_clk  (i_clk),
        .i_ctl  (lane_ctl),
        .i_pix  (r_blue),
        .i_area (area),
        .o_mean (mean_b)
    );

    assign o_out_valid     = r_ov;
    assign o_out_red       = r_or;
    assign o_out_green     = r_og;
    assign o_out_blue      = r_ob;
    assign o_result_column = r_ocol;
    assign o_result_row    = r_orow;
    assign o_frame_done    = r_ofd;

endmodule

/* dv/testbench.sv */
// Self-checking testbench of the box filter downscaler with random handshakes.
`timescale 1ns / 100ps

module testbench;

    typedef struct packed {
        logic [bfd_pkg::PIX_W-1:0] red;
        logic [bfd_pkg::PIX_W-1:0] green;
        logic [bfd_pkg::PIX_W-1:0] blue;
        logic                      sof;
    } t_pixel;

    typedef struct packed {
        logic [bfd_pkg::PIX_W-1:0] red;
        logic [bfd_pkg::PIX_W-1:0] green;
        logic [bfd_pkg::PIX_W-1:0] blue;
        logic [bfd_pkg::POS_W-1:0] column;
        logic [bfd_pkg::POS_W-1:0] row;
        logic                      done;
    } t_box_mean;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [bfd_pkg::IDX_W-1:0] i_cfg_idx;
    logic [bfd_pkg::CFG_W-1:0] i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [bfd_pkg::PIX_W-1:0] i_in_red;
    logic [bfd_pkg::PIX_W-1:0] i_in_green;
    logic [bfd_pkg::PIX_W-1:0] i_in_blue;
    logic                      i_start_of_frame;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic [bfd_pkg::PIX_W-1:0] o_out_red;
    logic [bfd_pkg::PIX_W-1:0] o_out_green;
    logic [bfd_pkg::PIX_W-1:0] o_out_blue;
    logic [bfd_pkg::POS_W-1:0] o_result_column;
    logic [bfd_pkg::POS_W-1:0] o_result_row;
    logic                      o_frame_done;

    box_filter_downscaler DUT (.*);

    t_pixel    pixel_queue[$];
    t_box_mean mean_queue[$];
    int        error_count;
    int        pixels_sent;
    int        means_seen;
    int        idle_cycles;
    bit        hold_output;
    int        driver_gap;
    int        monitor_gap;

    // Predictor state.
    int unsigned     p_in_w, p_in_h, p_out_w, p_out_h;
    longint unsigned red_sum[bfd_pkg::MAX_WIDTH];
    longint unsigned green_sum[bfd_pkg::MAX_WIDTH];
    longint unsigned blue_sum[bfd_pkg::MAX_WIDTH];
    int unsigned     col_pos, row_pos, col_in_box, row_in_box, box_col, box_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    task automatic report(input string what);
        $display("mismatch at %0t: %s", $time, what);
        error_count++;
    endtask

    function automatic void restart_raster();
        col_pos = 0;
        row_pos = 0;
        col_in_box = 0;
        row_in_box = 0;
        box_col = 0;
        box_row = 0;
    endfunction

    function automatic void predict_box_mean(input t_pixel px);
        int unsigned     rs, cs, k;
        longint unsigned area;
        t_box_mean       m;
        if (px.sof) restart_raster();
        if (p_out_w != 0 && p_out_h != 0 && p_out_w <= p_in_w && p_out_h <= p_in_h
                && p_out_w <= bfd_pkg::MAX_WIDTH) begin
            rs = p_in_h / p_out_h;
            cs = p_in_w / p_out_w;
            if (box_col < p_out_w && box_row < p_out_h && box_col < bfd_pkg::MAX_WIDTH) begin
                k = box_col;
                if (row_in_box == 0 && col_in_box == 0) begin
                    red_sum[k] = px.red;
                    green_sum[k] = px.green;
                    blue_sum[k] = px.blue;
                end else begin
                    red_sum[k] += px.red;
                    green_sum[k] += px.green;
                    blue_sum[k] += px.blue;
                end
                if (row_in_box + 1 >= rs && col_in_box + 1 >= cs) begin
                    area = longint'(rs) * cs;
                    m.red = bfd_pkg::PIX_W'(red_sum[k] / area);
                    m.green = bfd_pkg::PIX_W'(green_sum[k] / area);
                    m.blue = bfd_pkg::PIX_W'(blue_sum[k] / area);
                    m.column = bfd_pkg::POS_W'(box_col);
                    m.row = bfd_pkg::POS_W'(box_row);
                    m.done = (box_col + 1 == p_out_w) && (box_row + 1 == p_out_h);
                    mean_queue.push_back(m);
                end
            end
            col_in_box++;
            if (col_in_box >= cs) begin
                col_in_box = 0;
                if (box_col < p_out_w) box_col++;
            end
            if (box_col > p_out_w) box_col = p_out_w;
        end
        col_pos++;
        if (col_pos >= p_in_w) begin
            rs = (p_out_h != 0) ? p_in_h / p_out_h : 0;
            col_pos = 0;
            col_in_box = 0;
            box_col = 0;
            row_pos++;
            row_in_box++;
            if (row_in_box >= rs) begin
                row_in_box = 0;
                if (box_row < p_out_h) box_row++;
            end
            if (box_row > p_out_h) box_row = p_out_h;
            if (row_pos >= p_in_h) restart_raster();
        end
        if (row_pos > 13'h1FFF) restart_raster();
    endfunction

    // Driver.
    always @(posedge i_clk) begin
        int gap;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            driver_gap <= 0;
        end else if (i_in_valid && !o_in_stall) begin
            predict_box_mean({i_in_red, i_in_green, i_in_blue, i_start_of_frame});
            pixels_sent <= pixels_sent + 1;
            gap = $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
            if (gap == 0 && pixel_queue.size() != 0) begin
                {i_in_red, i_in_green, i_in_blue, i_start_of_frame} <= pixel_queue.pop_front();
            end else begin
                i_in_valid <= 1'b0;
                driver_gap <= (gap > 0) ? gap - 1 : 0;
            end
        end else if (!i_in_valid) begin
            if (driver_gap > 0) begin
                driver_gap <= driver_gap - 1;
            end else if (pixel_queue.size() != 0) begin
                {i_in_red, i_in_green, i_in_blue, i_start_of_frame} <= pixel_queue.pop_front();
                i_in_valid <= 1'b1;
            end
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_box_mean e;
        int        gap;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
            monitor_gap <= 0;
            idle_cycles <= 0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                means_seen <= means_seen + 1;
                if (mean_queue.size() == 0) begin
                    report("result with none expected");
                end else begin
                    e = mean_queue.pop_front();
                    if (o_out_red !== e.red)
                        report($sformatf("red %0d, expected %0d", o_out_red, e.red));
                    if (o_out_green !== e.green)
                        report($sformatf("green %0d, expected %0d", o_out_green, e.green));
                    if (o_out_blue !== e.blue)
                        report($sformatf("blue %0d, expected %0d", o_out_blue, e.blue));
                    if (o_result_column !== e.column)
                        report($sformatf("column %0d, expected %0d",
                                         o_result_column, e.column));
                    if (o_result_row !== e.row)
                        report($sformatf("row %0d, expected %0d", o_result_row, e.row));
                    if (o_frame_done !== e.done)
                        report($sformatf("frame_done %0b, expected %0b",
                                         o_frame_done, e.done));
                end
                gap = $urandom_range(0, 8) * ($urandom_range(0, 3) != 0);
                monitor_gap <= (gap > 0) ? gap - 1 : 0;
                i_out_stall <= hold_output || (gap > 0);
            end else if (hold_output) begin
                i_out_stall <= 1'b1;
            end else if (monitor_gap > 0) begin
                monitor_gap <= monitor_gap - 1;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > 20000) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pixel_queue.size() != 0 || i_in_valid || mean_queue.size() != 0)
            @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bfd_pkg::IDX_W-1:0] idx, input int unsigned value);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= bfd_pkg::CFG_W'(value);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            bfd_pkg::REG_IN_WIDTH:   p_in_w = value & 32'h1FFF;
            bfd_pkg::REG_IN_HEIGHT:  p_in_h = value & 32'h1FFF;
            bfd_pkg::REG_OUT_WIDTH:  p_out_w = value & 32'h1FFF;
            bfd_pkg::REG_OUT_HEIGHT: p_out_h = value & 32'h1FFF;
            default: ;
        endcase
    endtask

    task automatic set_sizes(input int unsigned iw, ih, ow, oh);
        wait_drained();
        write_reg(bfd_pkg::REG_IN_WIDTH, iw);
        write_reg(bfd_pkg::REG_IN_HEIGHT, ih);
        write_reg(bfd_pkg::REG_OUT_WIDTH, ow);
        write_reg(bfd_pkg::REG_OUT_HEIGHT, oh);
        repeat (2) @(posedge i_clk);
    endtask

    function automatic t_pixel random_pixel(input bit sof);
        t_pixel px;
        px.red = $urandom;
        px.green = $urandom;
        px.blue = $urandom;
        px.sof = sof;
        return px;
    endfunction

    task automatic queue_frames(input int unsigned count, input int unsigned frames);
        for (int f = 0; f < frames; f++)
            for (int n = 0; n < count; n++)
                pixel_queue.push_back(random_pixel(n == 0 && $urandom_range(0, 3) != 0));
    endtask

    initial begin
        int unsigned iw, ih, ow, oh;
        t_pixel px;
        error_count = 0;
        pixels_sent = 0;
        means_seen = 0;
        hold_output = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = bfd_pkg::REG_IN_WIDTH;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_red = '0;
        i_in_green = '0;
        i_in_blue = '0;
        i_start_of_frame = 1'b0;
        i_out_stall = 1'b0;
        p_in_w = 640;
        p_in_h = 480;
        p_out_w = 640;
        p_out_h = 480;
        restart_raster();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (20) @(posedge i_clk);

        // Directed: extreme channel values at the reset sizes, then a 2x2 box of extremes.
        pixel_queue.push_back('{8'hFF, 8'h00, 8'hFF, 1'b1});
        pixel_queue.push_back('{8'h00, 8'hFF, 8'h00, 1'b0});
        pixel_queue.push_back('{8'hAA, 8'h55, 8'h01, 1'b0});
        set_sizes(4, 4, 2, 2);
        pixel_queue.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b1});
        repeat (15) pixel_queue.push_back('{8'hFF, 8'hFF, 8'hFF, 1'b0});
        // Output larger than input: no results, position still moves.
        set_sizes(2, 2, 3, 1);
        repeat (3) pixel_queue.push_back(random_pixel(1'b0));
        // Zero sizes, and a one by one image.
        set_sizes(0, 0, 0, 0);
        repeat (2) pixel_queue.push_back(random_pixel(1'b0));
        set_sizes(1, 1, 1, 1);
        repeat (3) pixel_queue.push_back(random_pixel(1'b0));
        // Widest output row with height one, then the largest square size.
        set_sizes(8191, 1, 4096, 1);
        repeat (5) pixel_queue.push_back(random_pixel(1'b0));
        set_sizes(4096, 4096, 4096, 4096);
        pixel_queue.push_back(random_pixel(1'b1));

        // Random frames with small sizes and dropped margins.
        while (pixels_sent < 1500) begin
            ow = $urandom_range(1, 6);
            oh = $urandom_range(1, 4);
            iw = ow * $urandom_range(1, 3) + $urandom_range(0, 2);
            ih = oh * $urandom_range(1, 3) + $urandom_range(0, 2);
            if ($urandom_range(0, 9) == 0) ow = iw + 1;
            set_sizes(iw, ih, ow, oh);
            queue_frames(iw * ih, $urandom_range(1, 2));
            if ($urandom_range(0, 4) == 0)
                for (int n = 0; n < $urandom_range(1, 5); n++)
                    pixel_queue.push_back(random_pixel($urandom_range(0, 1)));
        end

        // Long output stall while pixels keep coming, so the input backs up.
        set_sizes(2, 2, 2, 2);
        hold_output = 1'b1;
        queue_frames(4, 30);
        repeat (3000) @(posedge i_clk);
        hold_output = 1'b0;
        wait_drained();

        $display("Sent %0d pixels over many frame sizes, checked %0d box means.",
                 pixels_sent, means_seen);
        if (error_count == 0 && mean_queue.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
